FILE: src/upva_pkg.sv
`default_nettype none
package upva_pkg;

  // Vertex index and appended index widths
  localparam int IDX_W = 16;
  localparam int CNT_W = 17;
  localparam int IDX_RANGE = 1 << IDX_W;

  // Per-entry epoch tag; an entry is marked when its tag equals the current epoch
  localparam int EPOCH_W = 8;

  localparam int MAX_VERTICES_DEF = 65536;

  // Stream payload widths
  localparam int IN_DATA_W = 48;
  localparam int OUT_DATA_W = 72;

  typedef logic [IDX_W-1:0]   idx_t;
  typedef logic [CNT_W-1:0]   cnt_t;
  typedef logic [EPOCH_W-1:0] epoch_t;

endpackage
`default_nettype wire

FILE: src/upva_mark_store.sv
`default_nettype none
module upva_mark_store #(
  parameter int DEPTH = upva_pkg::MAX_VERTICES_DEF
) (
  input  wire                          clk,
  input  wire                          rd_en,
  input  wire  [$clog2(DEPTH)-1:0]     rd_addr_c,
  input  wire  [$clog2(DEPTH)-1:0]     rd_addr_a,
  input  wire  [$clog2(DEPTH)-1:0]     rd_addr_b,
  output upva_pkg::epoch_t             rd_tag_c,
  output upva_pkg::epoch_t             rd_tag_a,
  output upva_pkg::epoch_t             rd_tag_b,
  input  wire                          wr_en,
  input  wire  [$clog2(DEPTH)-1:0]     wr_addr,
  input  wire  upva_pkg::epoch_t       wr_tag
);
  import upva_pkg::*;

  // Two copies written together: copy x serves c and a, copy y serves b.
  epoch_t mem_x [DEPTH];
  epoch_t mem_y [DEPTH];

  epoch_t tag_c_r;
  epoch_t tag_a_r;
  epoch_t tag_b_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_x[wr_addr] <= wr_tag;
    end
    if (rd_en) begin
      tag_c_r <= mem_x[rd_addr_c];
      tag_a_r <= mem_x[rd_addr_a];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_y[wr_addr] <= wr_tag;
    end
    if (rd_en) begin
      tag_b_r <= mem_y[rd_addr_b];
    end
  end

  assign rd_tag_c = tag_c_r;
  assign rd_tag_a = tag_a_r;
  assign rd_tag_b = tag_b_r;

endmodule
`default_nettype wire

FILE: src/unique_provoking_vertex_assign.sv
`default_nettype none
// Channel | Dir | Beat contents (tdata low bits first)                   | tuser
// in_     | in  | vertex_a[15:0], vertex_b[31:16], vertex_c[47:32]        | first_triangle
// out_    | out | out_first[16:0], out_second[33:17],                     | duplicated
//         |     | out_controlling[50:34], copy_source[66:51], zero pad    |
// cfg_    | in  | vertex_count[16:0], written when cfg_wr_en is high      | -
//
// One triangle per cycle sustained while the output is not stalled and no clear pass runs;
// a beat passes the mark memory read, then choose/write-back into the output register.
// Marks are epoch-tagged in a replicated memory (two read ports plus one);
// a first_triangle beat bumps the epoch instead of clearing.
// After reset, and when the epoch would wrap, a clear pass over all DEPTH entries
// (DEPTH = min(MAX_VERTICES, 65536)) holds in_tready low.
// A stalled output holds the stage behind it; the output register lets a new
// beat enter while a result waits.
module unique_provoking_vertex_assign #(
  parameter int MAX_VERTICES = upva_pkg::MAX_VERTICES_DEF
) (
  input  wire                             clk,
  input  wire                             rst_n,
  input  wire                             in_tvalid,
  output logic                            in_tready,
  input  wire  [upva_pkg::IN_DATA_W-1:0]  in_tdata,   // vertex_a, vertex_b, vertex_c
  input  wire                             in_tuser,   // first_triangle
  output logic                            out_tvalid,
  input  wire                             out_tready,
  output logic [upva_pkg::OUT_DATA_W-1:0] out_tdata,  // first, second, controlling, copy_source
  output logic                            out_tuser,  // duplicated
  input  wire                             cfg_wr_en,
  input  wire  [upva_pkg::CNT_W-1:0]      cfg_wr_data // vertex_count
);
  import upva_pkg::*;

  localparam int DEPTH  = (MAX_VERTICES < IDX_RANGE) ? MAX_VERTICES : IDX_RANGE;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);

  localparam logic ST_CLEAR = 1'b0;
  localparam logic ST_RUN   = 1'b1;

  function automatic logic idx_oob(input idx_t v);
    return ({16'd0, v} >= 32'(MAX_VERTICES));
  endfunction

  function automatic logic [ADDR_W-1:0] idx_addr(input idx_t v);
    return idx_oob(v) ? '0 : v[ADDR_W-1:0];
  endfunction

  logic              state_r, state_nxt;
  logic [ADDR_W-1:0] clr_addr_r, clr_addr_nxt;
  epoch_t            epoch_r, epoch_nxt;
  cnt_t              vertex_count_r;
  cnt_t              added_r, added_nxt;

  logic              s1_valid_r;
  logic              s1_first_r;
  idx_t              s1_a_r, s1_b_r, s1_c_r;
  logic              fw_valid_r;
  logic [ADDR_W-1:0] fw_addr_r;

  logic              out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r;
  logic              out_dup_r;

  idx_t in_a, in_b, in_c;
  logic in_accept, s1_fire, wrap_req;

  epoch_t tag_c, tag_a, tag_b;
  logic used_c, used_a, used_b;
  logic [ADDR_W-1:0] addr_c, addr_a, addr_b;

  logic              run_wr_en;
  logic [ADDR_W-1:0] run_wr_addr;
  logic              mem_wr_en;
  logic [ADDR_W-1:0] mem_wr_addr;
  epoch_t            mem_wr_tag;

  cnt_t eff_added;
  cnt_t o_first, o_second, o_ctrl;
  logic o_dup;
  idx_t o_src;

  assign in_a = in_tdata[15:0];
  assign in_b = in_tdata[31:16];
  assign in_c = in_tdata[47:32];

  assign s1_fire  = s1_valid_r && (!out_valid_r || out_tready);
  // A first_triangle at the last epoch waits for the choice stage to drain, then a clear pass.
  assign wrap_req = (state_r == ST_RUN) && in_tvalid && in_tuser && (&epoch_r) && !s1_valid_r;
  assign in_tready = (state_r == ST_RUN) && (!s1_valid_r || s1_fire) &&
                     !(in_tuser && (&epoch_r));
  assign in_accept = in_tvalid && in_tready;

  upva_mark_store #(
    .DEPTH (DEPTH)
  ) u_marks (
    .clk       (clk),
    .rd_en     (in_accept),
    .rd_addr_c (idx_addr(in_c)),
    .rd_addr_a (idx_addr(in_a)),
    .rd_addr_b (idx_addr(in_b)),
    .rd_tag_c  (tag_c),
    .rd_tag_a  (tag_a),
    .rd_tag_b  (tag_b),
    .wr_en     (mem_wr_en),
    .wr_addr   (mem_wr_addr),
    .wr_tag    (mem_wr_tag)
  );

  // Choice stage; the forward covers the mark written at this beat's read edge.
  always_comb begin
    addr_c = idx_addr(s1_c_r);
    addr_a = idx_addr(s1_a_r);
    addr_b = idx_addr(s1_b_r);
    used_c = idx_oob(s1_c_r) || (tag_c == epoch_r) || (fw_valid_r && fw_addr_r == addr_c);
    used_a = idx_oob(s1_a_r) || (tag_a == epoch_r) || (fw_valid_r && fw_addr_r == addr_a);
    used_b = idx_oob(s1_b_r) || (tag_b == epoch_r) || (fw_valid_r && fw_addr_r == addr_b);
    eff_added = s1_first_r ? '0 : added_r;
    o_dup = 1'b0;
    o_src = '0;
    run_wr_en = 1'b0;
    run_wr_addr = addr_c;
    if (!used_c) begin
      o_first  = CNT_W'(s1_a_r);
      o_second = CNT_W'(s1_b_r);
      o_ctrl   = CNT_W'(s1_c_r);
      run_wr_en = 1'b1;
    end else if (!used_a) begin
      o_first  = CNT_W'(s1_b_r);
      o_second = CNT_W'(s1_c_r);
      o_ctrl   = CNT_W'(s1_a_r);
      run_wr_en = 1'b1;
      run_wr_addr = addr_a;
    end else if (!used_b) begin
      o_first  = CNT_W'(s1_c_r);
      o_second = CNT_W'(s1_a_r);
      o_ctrl   = CNT_W'(s1_b_r);
      run_wr_en = 1'b1;
      run_wr_addr = addr_b;
    end else begin
      o_first  = CNT_W'(s1_a_r);
      o_second = CNT_W'(s1_b_r);
      o_ctrl   = vertex_count_r + eff_added;
      o_dup = 1'b1;
      o_src = s1_c_r;
    end
    added_nxt = o_dup ? eff_added + CNT_W'(1) : eff_added;
  end

  always_comb begin
    if (state_r == ST_CLEAR) begin
      mem_wr_en   = 1'b1;
      mem_wr_addr = clr_addr_r;
      mem_wr_tag  = '0;
    end else begin
      mem_wr_en   = s1_fire && run_wr_en;
      mem_wr_addr = run_wr_addr;
      mem_wr_tag  = epoch_r;
    end
  end

  always_comb begin
    state_nxt = state_r;
    clr_addr_nxt = clr_addr_r;
    epoch_nxt = epoch_r;
    case (state_r)
      ST_CLEAR: begin
        clr_addr_nxt = clr_addr_r + ADDR_W'(1);
        if (clr_addr_r == LAST_ADDR) begin
          state_nxt = ST_RUN;
          epoch_nxt = EPOCH_W'(1);
        end
      end
      ST_RUN: begin
        if (wrap_req) begin
          state_nxt = ST_CLEAR;
          clr_addr_nxt = '0;
        end else if (in_accept && in_tuser) begin
          epoch_nxt = epoch_r + EPOCH_W'(1);
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
        clr_addr_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_CLEAR;
      clr_addr_r     <= '0;
      epoch_r        <= '0;
      vertex_count_r <= '0;
      added_r        <= '0;
      s1_valid_r     <= 1'b0;
      fw_valid_r     <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      clr_addr_r <= clr_addr_nxt;
      epoch_r    <= epoch_nxt;
      if (cfg_wr_en) begin
        vertex_count_r <= cfg_wr_data;
      end
      if (s1_fire) begin
        added_r <= added_nxt;
      end
      if (in_accept) begin
        s1_valid_r <= 1'b1;
        fw_valid_r <= s1_fire && run_wr_en && !in_tuser;
      end else if (s1_fire) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_first_r <= in_tuser;
      s1_a_r     <= in_a;
      s1_b_r     <= in_b;
      s1_c_r     <= in_c;
      fw_addr_r  <= run_wr_addr;
    end
    if (s1_fire) begin
      out_data_r <= {5'd0, o_src, o_ctrl, o_second, o_first};
      out_dup_r  <= o_dup;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_dup_r;

endmodule
`default_nettype wire
